// ----- sv/misu_pkg.sv -----
package misu_pkg;

    // Sizing of the stores
    localparam int NODES      = 128;
    localparam int MAX_DEGREE = 64;
    localparam int PROB_BITS  = 16;
    localparam int RAND_W     = 16;

    localparam int NODE_W  = $clog2(NODES);
    localparam int SLOT_W  = $clog2(MAX_DEGREE);
    localparam int DEG_W   = $clog2(MAX_DEGREE + 1);
    localparam int NADDR_W = NODE_W + SLOT_W;
    localparam int FIELD_W = 8;
    localparam int VALUE_W = 16;

    // Operation codes
    localparam logic [1:0] OP_LOAD_NODE = 2'd0;
    localparam logic [1:0] OP_WRITE_NB  = 2'd1;
    localparam logic [1:0] OP_WRITE_THR = 2'd2;
    localparam logic [1:0] OP_UPDATE    = 2'd3;

    typedef struct packed {
        logic [1:0]         operation;
        logic [NODE_W-1:0]  node;
        logic [SLOT_W-1:0]  slot;
        logic [VALUE_W-1:0] value;
        logic               spin_in;
        logic [RAND_W-1:0]  random_value;
    } misu_in_t;

    typedef struct packed {
        logic                      new_spin;
        logic                      flipped;
        logic signed [FIELD_W-1:0] local_field;
        logic                      status;
    } misu_out_t;

    // Control of the shared field accumulator
    typedef struct packed {
        logic clear;
        logic add;
        logic spin;
    } misu_acc_ctl_t;

    // Bring the random fraction to the threshold's fixed-point format
    function automatic logic [PROB_BITS-1:0] align_random(input logic [RAND_W-1:0] r);
        logic [RAND_W+PROB_BITS-1:0] wide;
        wide = {{PROB_BITS{1'b0}}, r} << PROB_BITS;
        return wide[RAND_W+PROB_BITS-1:RAND_W];
    endfunction

endpackage

// ----- sv/metropolis_ising_spin_update.sv -----
// Metropolis single-spin update engine for an Ising model on a graph.
// Input channel cmd/cmd_valid/cmd_stall carries one command beat: load node
// (spin and degree), write neighbour, write threshold, or update a node.
// Output channel res/res_valid/res_stall returns exactly one result beat per
// command: new spin, flip flag, local field and a reject status.
// Load and write commands finish in the accept cycle; their result is loaded
// into the output register at the end of that cycle, and they can be taken
// every cycle while res_stall does not hold the output register. In an
// update the neighbour scan reads one neighbour index and one neighbour spin
// per cycle through a two-deep read pipeline into a single accumulator; the
// threshold lookup and decision steps follow the scan.
// One command is processed at a time: cmd_stall is high while an update runs,
// so a new command is taken only after the update has finished.
// When res_stall holds the output register, a finished update waits in its
// last step and no new command is taken until the result can be written.
// Reset clears the sequencer, the output valid and the field accumulator only;
// the spin, degree, neighbour and threshold stores hold nothing defined until loaded.
module metropolis_ising_spin_update
    import misu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  misu_in_t  cmd,
    input  logic      cmd_valid,
    output logic      cmd_stall,
    output misu_out_t res,
    output logic      res_valid,
    input  logic      res_stall
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_HEAD = 3'd1;
    localparam logic [2:0] ST_SCAN = 3'd2;
    localparam logic [2:0] ST_THR  = 3'd3;
    localparam logic [2:0] ST_DEC  = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [NODE_W-1:0]   node_reg, node_next;
    logic [RAND_W-1:0]   rnd_reg, rnd_next;
    logic                own_reg, own_next;
    logic [DEG_W-1:0]    deg_reg, deg_next;
    logic [DEG_W-1:0]    issue_reg, issue_next;
    logic                nb_v_reg, nb_v_next;
    logic                sp_v_reg, sp_v_next;
    logic                res_valid_reg, res_valid_next;
    misu_out_t           res_reg, res_next;

    logic                accept;
    logic                out_free;
    logic                issue_go;
    logic                res_load;

    logic                spin_we;
    logic [NODE_W-1:0]   spin_waddr;
    logic                spin_wdata;
    logic [NODE_W-1:0]   spin_raddr;
    logic                spin_rdata;
    logic                deg_we;
    logic [DEG_W-1:0]    deg_rdata;
    logic                nb_we;
    logic [NADDR_W-1:0]  nb_raddr;
    logic [NODE_W-1:0]   nb_rdata;
    logic                thr_we;
    logic [PROB_BITS-1:0] thr_rdata;

    misu_acc_ctl_t             acc_ctl;
    logic signed [FIELD_W-1:0] h;
    logic [SLOT_W-1:0]         thr_idx;
    logic                      flip;
    logic                      load_ok;
    logic                      nb_ok;

    // Handshake
    assign out_free  = !res_valid_reg || !res_stall;
    assign cmd_stall = (state_reg != ST_IDLE) || !out_free;
    assign accept    = cmd_valid && !cmd_stall;
    assign issue_go  = (state_reg == ST_SCAN) && (issue_reg < deg_reg);
    assign res_load  = (state_reg == ST_DEC) && out_free;

    // Range checks for load-node and write-neighbour commands
    assign load_ok = (cmd.value <= VALUE_W'(MAX_DEGREE));
    assign nb_ok   = (cmd.value < VALUE_W'(NODES));

    // Store write and read ports
    always_comb
    begin
        spin_we    = 1'b0;
        spin_waddr = cmd.node;
        spin_wdata = cmd.spin_in;
        if (accept && cmd.operation == OP_LOAD_NODE && load_ok)
        begin
            spin_we = 1'b1;
        end
        else if (res_load && flip)
        begin
            spin_we    = 1'b1;
            spin_waddr = node_reg;
            spin_wdata = !own_reg;
        end
        deg_we     = accept && cmd.operation == OP_LOAD_NODE && load_ok;
        nb_we      = accept && cmd.operation == OP_WRITE_NB && nb_ok;
        thr_we     = accept && cmd.operation == OP_WRITE_THR;
        spin_raddr = (state_reg == ST_IDLE) ? cmd.node : nb_rdata;
        nb_raddr   = {node_reg, issue_reg[SLOT_W-1:0]};
    end

    misu_ram #(.WIDTH(1), .DEPTH(NODES)) u_spin_ram (
        .clk   (clk),
        .we    (spin_we),
        .waddr (spin_waddr),
        .wdata (spin_wdata),
        .raddr (spin_raddr),
        .rdata (spin_rdata)
    );

    misu_ram #(.WIDTH(DEG_W), .DEPTH(NODES)) u_deg_ram (
        .clk   (clk),
        .we    (deg_we),
        .waddr (cmd.node),
        .wdata (cmd.value[DEG_W-1:0]),
        .raddr (cmd.node),
        .rdata (deg_rdata)
    );

    misu_ram #(.WIDTH(NODE_W), .DEPTH(NODES * MAX_DEGREE)) u_nb_ram (
        .clk   (clk),
        .we    (nb_we),
        .waddr ({cmd.node, cmd.slot}),
        .wdata (cmd.value[NODE_W-1:0]),
        .raddr (nb_raddr),
        .rdata (nb_rdata)
    );

    misu_ram #(.WIDTH(PROB_BITS), .DEPTH(MAX_DEGREE)) u_thr_ram (
        .clk   (clk),
        .we    (thr_we),
        .waddr (cmd.slot),
        .wdata (cmd.value[PROB_BITS-1:0]),
        .raddr (thr_idx),
        .rdata (thr_rdata)
    );

    // Shared field accumulator and decision
    always_comb
    begin
        acc_ctl.clear = (state_reg == ST_HEAD);
        acc_ctl.add   = sp_v_reg;
        acc_ctl.spin  = spin_rdata;
    end

    misu_field_unit u_field (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (acc_ctl),
        .own_spin (own_reg),
        .rnd      (rnd_reg),
        .thr      (thr_rdata),
        .h        (h),
        .thr_idx  (thr_idx),
        .flip     (flip)
    );

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        node_next      = node_reg;
        rnd_next       = rnd_reg;
        own_next       = own_reg;
        deg_next       = deg_reg;
        issue_next     = issue_reg;
        nb_v_next      = issue_go;
        sp_v_next      = nb_v_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && res_stall;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_next = '0;
                    case (cmd.operation)
                        OP_LOAD_NODE:
                        begin
                            res_next.new_spin = load_ok ? cmd.spin_in : 1'b0;
                            res_next.status   = !load_ok;
                            res_valid_next    = 1'b1;
                        end
                        OP_WRITE_NB:
                        begin
                            res_next.status = !nb_ok;
                            res_valid_next  = 1'b1;
                        end
                        OP_WRITE_THR:
                        begin
                            res_valid_next = 1'b1;
                        end
                        default:
                        begin
                            node_next  = cmd.node;
                            rnd_next   = cmd.random_value;
                            state_next = ST_HEAD;
                        end
                    endcase
                end
            end
            ST_HEAD:
            begin
                own_next   = spin_rdata;
                deg_next   = deg_rdata;
                issue_next = '0;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (issue_go)
                begin
                    issue_next = issue_reg + DEG_W'(1);
                end
                else if (!nb_v_reg && !sp_v_reg)
                begin
                    state_next = ST_THR;
                end
            end
            ST_THR:
            begin
                state_next = ST_DEC;
            end
            ST_DEC:
            begin
                if (out_free)
                begin
                    res_next.new_spin    = own_reg ^ flip;
                    res_next.flipped     = flip;
                    res_next.local_field = h;
                    res_next.status      = 1'b0;
                    res_valid_next       = 1'b1;
                    state_next           = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            nb_v_reg      <= 1'b0;
            sp_v_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            nb_v_reg      <= nb_v_next;
            sp_v_reg      <= sp_v_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        node_reg  <= node_next;
        rnd_reg   <= rnd_next;
        own_reg   <= own_next;
        deg_reg   <= deg_next;
        issue_reg <= issue_next;
        res_reg   <= res_next;
    end

    assign res       = res_reg;
    assign res_valid = res_valid_reg;

endmodule

// ----- sv/misu_ram.sv -----
module misu_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/misu_field_unit.sv -----
module misu_field_unit
    import misu_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  misu_acc_ctl_t             ctl,
    input  logic                      own_spin,
    input  logic [RAND_W-1:0]         rnd,
    input  logic [PROB_BITS-1:0]      thr,
    output logic signed [FIELD_W-1:0] h,
    output logic [SLOT_W-1:0]         thr_idx,
    output logic                      flip
);

    logic signed [FIELD_W-1:0] h_reg;
    logic signed [FIELD_W-1:0] h_next;
    logic signed [FIELD_W-1:0] k;
    logic signed [FIELD_W-1:0] k_m1;
    logic                      k_pos;

    // Shared adder: one neighbour spin per beat, +1 or -1
    always_comb
    begin
        h_next = h_reg;
        if (ctl.clear)
        begin
            h_next = '0;
        end
        else if (ctl.add)
        begin
            h_next = ctl.spin ? h_reg + FIELD_W'(1) : h_reg - FIELD_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_reg <= '0;
        end
        else
        begin
            h_reg <= h_next;
        end
    end

    // Half energy change k = s*h, threshold index k-1
    always_comb
    begin
        k       = own_spin ? h_reg : -h_reg;
        k_pos   = (k > 0);
        k_m1    = k - FIELD_W'(1);
        thr_idx = k_m1[SLOT_W-1:0];
        flip    = k_pos ? (align_random(rnd) < thr) : 1'b1;
    end

    assign h = h_reg;

endmodule
